### sv/tpc_pkg.sv
// Shared types, constants and helpers for the tile plane pixel compositor.
package tpc_pkg;

   localparam int VIDEO_MEMORY_BYTES = 65536;
   localparam int VRAM_AW = $clog2(VIDEO_MEMORY_BYTES);
   localparam int COLOR_ENTRIES = 64;
   localparam int CRAM_AW = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   localparam logic [1:0] OP_VRAM_WRITE = 2'd0;
   localparam logic [1:0] OP_CRAM_WRITE = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;

   localparam logic [2:0] REG_PLANE_A_BASE = 3'd0;
   localparam logic [2:0] REG_PLANE_B_BASE = 3'd1;
   localparam logic [2:0] REG_WINDOW_BASE = 3'd2;
   localparam logic [2:0] REG_PLANE_SIZE = 3'd3;
   localparam logic [2:0] REG_WINDOW_H = 3'd4;
   localparam logic [2:0] REG_WINDOW_V = 3'd5;
   localparam logic [2:0] REG_BACKDROP = 3'd6;
   localparam logic [2:0] REG_WIDE_MODE = 3'd7;

   typedef struct packed {
      logic [2:0] plane_a_base;
      logic [2:0] plane_b_base;
      logic [4:0] window_base;
      logic [5:0] plane_size;
      logic [7:0] window_h;
      logic [7:0] window_v;
      logic [5:0] backdrop;
      logic       wide_mode;
   } cfg_type;

   // Work item for the back end: a write, or a render with resolved addresses.
   typedef struct packed {
      logic [1:0]         op;
      logic [VRAM_AW-1:0] addr;
      logic [15:0]        data;
      logic [VRAM_AW-1:0] entry_a;
      logic [VRAM_AW-1:0] entry_b;
      logic [2:0]         fine_xa;
      logic [2:0]         fine_ya;
      logic [2:0]         fine_xb;
      logic [2:0]         fine_yb;
   } job_type;

   function automatic logic [7:0] level_scale(input logic [2:0] c);
      level_scale = {5'd0, c} * 8'd34;
   endfunction

endpackage

### sv/tile_plane_pixel_compositor.sv
// Top level of the tile plane pixel compositor.
// Usage: the req_ channel carries transactions: a video memory byte write, a
// color memory word write, or a render of one pixel with resolved scroll values.
// Writes produce no rsp_ transaction; each render produces exactly one, in order.
// The csr_ port writes the eight configuration registers; the user must do so
// only while the block is idle, as the block itself does not enforce this.
// The front end decodes and registers nametable addresses, then a four-entry
// queue feeds the back end. The back end reads the video memory over two ports:
// entry high bytes, entry low bytes, then the pattern bytes of both planes, one
// port per plane, followed by a color memory read. Throughput: a new render is
// taken once the previous one has issued its entry and pattern fetches on the
// two-port video memory; writes are taken one per cycle while the ports are
// free and the output is not stalled.
// Reset clears all control state and sets the registers to their defaults
// (wide mode on); the memories are not cleared and must be written before use.
// When the receiver stalls, the result holds in the output register, the back
// pipeline freezes once s3 holds a result, the queue fills and req_ready drops.
module tile_plane_pixel_compositor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [15:0]        req_address,
   input  logic [15:0]        req_write_data,
   input  logic [8:0]         req_pixel_x,
   input  logic [7:0]         req_pixel_y,
   input  logic signed [10:0] req_hscroll_a,
   input  logic signed [10:0] req_hscroll_b,
   input  logic signed [10:0] req_vscroll_a,
   input  logic signed [10:0] req_vscroll_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_plane_high,
   output logic               rsp_plane_drawn,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_write_data
);

   tpc_pkg::cfg_type cfg_ff, cfg_in;
   tpc_pkg::job_type f_job, q_job;
   logic             f_valid, f_ready, q_valid, q_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tpc_pkg::REG_PLANE_A_BASE: cfg_in.plane_a_base = csr_write_data[2:0];
            tpc_pkg::REG_PLANE_B_BASE: cfg_in.plane_b_base = csr_write_data[2:0];
            tpc_pkg::REG_WINDOW_BASE: cfg_in.window_base = csr_write_data[4:0];
            tpc_pkg::REG_PLANE_SIZE: cfg_in.plane_size = csr_write_data[5:0];
            tpc_pkg::REG_WINDOW_H: cfg_in.window_h = csr_write_data;
            tpc_pkg::REG_WINDOW_V: cfg_in.window_v = csr_write_data;
            tpc_pkg::REG_BACKDROP: cfg_in.backdrop = csr_write_data[5:0];
            tpc_pkg::REG_WIDE_MODE: cfg_in.wide_mode = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0, wide_mode: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpc_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_valid), .in_ready(req_ready),
      .operation(req_operation), .address(req_address), .write_data(req_write_data),
      .pixel_x(req_pixel_x), .pixel_y(req_pixel_y),
      .hscroll_a(req_hscroll_a), .hscroll_b(req_hscroll_b),
      .vscroll_a(req_vscroll_a), .vscroll_b(req_vscroll_b),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   tpc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_job(f_job),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job)
   );

   tpc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_plane_high(rsp_plane_high), .rsp_plane_drawn(rsp_plane_drawn)
   );

endmodule

### sv/tpc_ram.sv
// Generic single-write, dual-read RAM with registered reads.
module tpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_1,
   output logic [WIDTH-1:0]         rd_data_0,
   output logic [WIDTH-1:0]         rd_data_1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_0 <= mem[rd_addr_0];
      rd_data_1 <= mem[rd_addr_1];
   end

endmodule

### sv/tpc_front.sv
// Front end: decodes items, resolves scroll and window, and computes entry addresses.
module tpc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  tpc_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [1:0]                  operation,
   input  logic [15:0]                 address,
   input  logic [15:0]                 write_data,
   input  logic [8:0]                  pixel_x,
   input  logic [7:0]                  pixel_y,
   input  logic signed [10:0]          hscroll_a,
   input  logic signed [10:0]          hscroll_b,
   input  logic signed [10:0]          vscroll_a,
   input  logic signed [10:0]          vscroll_b,
   output logic                        job_valid,
   input  logic                        job_ready,
   output tpc_pkg::job_type            job
);

   logic                 valid_ff, valid_in;
   tpc_pkg::job_type     job_ff, job_in;
   logic [10:0]          xa, ya, xb, yb;
   logic [5:0]           cx, hpos;
   logic [4:0]           cy;
   logic                 ih, iv, win;
   logic [15:0]          off_a, off_b, off_w;

   function automatic logic [15:0] plane_offset(input logic [5:0] size,
                                                input logic [10:0] px,
                                                input logic [10:0] py);
      logic [6:0] tx, ty;
      logic [15:0] flat;
      tx = px[9:3];
      ty = py[9:3];
      case (size[1:0])
         2'd0: begin
            tx = {2'b0, tx[4:0]};
         end
         2'd1: begin
            tx = {1'b0, tx[5:0]};
         end
         default: begin
         end
      endcase
      case (size[5:4])
         2'd0: begin
            ty = {2'b0, ty[4:0]};
         end
         2'd1: begin
            ty = {1'b0, ty[5:0]};
         end
         default: begin
         end
      endcase
      case (size[1:0])
         2'd0: flat = {4'd0, ty, 5'd0} + {9'd0, tx};
         2'd1: flat = {3'd0, ty, 6'd0} + {9'd0, tx};
         default: flat = {2'd0, ty, 7'd0} + {9'd0, tx};
      endcase
      plane_offset = {flat[14:0], 1'b0};
   endfunction

   assign xa = {2'b0, pixel_x} - hscroll_a;
   assign xb = {2'b0, pixel_x} - hscroll_b;
   assign ya = {3'b0, pixel_y} + vscroll_a;
   assign yb = {3'b0, pixel_y} + vscroll_b;

   assign cx = pixel_x[8:3];
   assign cy = pixel_y[7:3];
   assign hpos = {cfg.window_h[4:0], 1'b0};
   assign ih = cfg.window_h[7] ? (cx >= hpos) : (cx < hpos);
   assign iv = cfg.window_v[7] ? (cy >= cfg.window_v[4:0]) : (cy < cfg.window_v[4:0]);
   assign win = ih && iv;

   assign off_a = plane_offset(cfg.plane_size, xa, ya);
   assign off_b = plane_offset(cfg.plane_size, xb, yb);
   assign off_w = cfg.wide_mode ? {4'd0, cy, cx, 1'b0} + {cfg.window_base, 11'd0}
                                : {5'd0, cy, 5'd0, 1'b0} + {9'd0, cx, 1'b0}
                                  + {cfg.window_base, 11'd0};

   assign in_ready = !valid_ff || job_ready;

   always_comb begin
      valid_in = valid_ff;
      job_in = job_ff;
      if (job_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = (operation == tpc_pkg::OP_VRAM_WRITE)
                 || (operation == tpc_pkg::OP_CRAM_WRITE)
                 || (operation == tpc_pkg::OP_RENDER);
         job_in.op = operation;
         job_in.addr = address[tpc_pkg::VRAM_AW-1:0];
         job_in.data = write_data;
         job_in.entry_b = off_b[tpc_pkg::VRAM_AW-1:0]
                        + {cfg.plane_b_base, 13'd0};
         job_in.fine_xb = xb[2:0];
         job_in.fine_yb = yb[2:0];
         if (win) begin
            job_in.entry_a = off_w[tpc_pkg::VRAM_AW-1:0];
            job_in.fine_xa = pixel_x[2:0];
            job_in.fine_ya = pixel_y[2:0];
         end else begin
            job_in.entry_a = off_a[tpc_pkg::VRAM_AW-1:0]
                           + {cfg.plane_a_base, 13'd0};
            job_in.fine_xa = xa[2:0];
            job_in.fine_ya = ya[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job = job_ff;

endmodule

### sv/tpc_queue.sv
// Short FIFO between the front and back ends.
module tpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tpc_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tpc_pkg::job_type pop_job
);

   tpc_pkg::job_type          slot_ff [tpc_pkg::QUEUE_DEPTH];
   logic [tpc_pkg::QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [tpc_pkg::QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                         push, pop;

   assign push_ready = cnt_ff != (tpc_pkg::QUEUE_AW+1)'(tpc_pkg::QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_job = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{tpc_pkg::QUEUE_AW{1'b0}}, push} - {{tpc_pkg::QUEUE_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### sv/tpc_back.sv
// Back end: memory writes, entry and pattern fetches, priority and color output.
module tpc_back (
   input  logic             clock,
   input  logic             reset,
   input  tpc_pkg::cfg_type cfg,
   input  logic             job_valid,
   output logic             job_ready,
   input  tpc_pkg::job_type job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_plane_high,
   output logic             rsp_plane_drawn
);

   localparam int AW = tpc_pkg::VRAM_AW;

   // Stage valids: s0 entry hi, s1 entry lo, s2 pattern, s3 color; bit 4 stays zero and out_ff marks the output.
   logic [4:0]         v_ff, v_in;
   tpc_pkg::job_type   j1_ff, j2_ff, j3_ff;
   logic [7:0]         hi_a_ff, hi_b_ff;
   logic [15:0]        ent_a_ff, ent_b_ff;
   logic [5:0]         pick_ff;
   logic               high_ff, drawn_ff, high2_ff, drawn2_ff;
   logic [7:0]         red_ff, green_ff, blue_ff;
   logic               out_ff, out_in;
   logic [AW-1:0]      ra0_ff, ra1_ff;

   logic               stall, take;
   logic               vwe, cwe;
   logic [AW-1:0]      ra0, ra1;
   logic [7:0]         rd0, rd1;
   logic [15:0]        cword;
   logic [15:0]        ea, eb;
   logic [2:0]         ixa, ixb;
   logic [2:0]         pxa, pya, pxb, pyb;
   logic [3:0]         na, nb;
   logic [5:0]         ca, cb, pick, cram_ra;
   logic               hi;

   // Pipeline advances only when the output slot can take what the last stage holds.
   assign stall = out_ff && !rsp_ready && v_ff[3];
   assign take = job_valid && job_ready;
   // The two read ports are busy for the entry low bytes and the pattern bytes.
   assign job_ready = !stall && !v_ff[0] && !v_ff[1];

   assign vwe = take && job.op == tpc_pkg::OP_VRAM_WRITE;
   assign cwe = take && job.op == tpc_pkg::OP_CRAM_WRITE;

   assign ea = {hi_a_ff, rd0};
   assign eb = {hi_b_ff, rd1};

   always_comb begin
      pxa = ea[11] ? ~j2_ff.fine_xa : j2_ff.fine_xa;
      pya = ea[12] ? ~j2_ff.fine_ya : j2_ff.fine_ya;
      pxb = eb[11] ? ~j2_ff.fine_xb : j2_ff.fine_xb;
      pyb = eb[12] ? ~j2_ff.fine_yb : j2_ff.fine_yb;
      ra0 = job.entry_a;
      ra1 = job.entry_b;
      if (stall) begin
         // Re-read the same addresses so the read data holds.
         ra0 = ra0_ff;
         ra1 = ra1_ff;
      end else if (v_ff[0]) begin
         ra0 = j1_ff.entry_a + AW'(1);
         ra1 = j1_ff.entry_b + AW'(1);
      end else if (v_ff[1]) begin
         ra0 = AW'({ea[10:0], pya, pxa[2:1]});
         ra1 = AW'({eb[10:0], pyb, pxb[2:1]});
      end
   end

   tpc_ram #(.WIDTH(8), .DEPTH(tpc_pkg::VIDEO_MEMORY_BYTES)) u_vram (
      .clock(clock), .wr_en(vwe), .wr_addr(job.addr), .wr_data(job.data[7:0]),
      .rd_addr_0(ra0), .rd_addr_1(ra1), .rd_data_0(rd0), .rd_data_1(rd1)
   );

   // Pattern decode in stage s2.
   always_comb begin
      ixa = ent_a_ff[11] ? ~j3_ff.fine_xa : j3_ff.fine_xa;
      ixb = ent_b_ff[11] ? ~j3_ff.fine_xb : j3_ff.fine_xb;
      na = ixa[0] ? rd0[3:0] : rd0[7:4];
      nb = ixb[0] ? rd1[3:0] : rd1[7:4];
      ca = (na != 4'd0) ? {ent_a_ff[14:13], na} : 6'd0;
      cb = (nb != 4'd0) ? {ent_b_ff[14:13], nb} : 6'd0;
      hi = 1'b0;
      if (ent_a_ff[15] && ca != 6'd0) begin
         pick = ca; hi = 1'b1;
      end else if (ent_b_ff[15] && cb != 6'd0) begin
         pick = cb; hi = 1'b1;
      end else if (ca != 6'd0) begin
         pick = ca;
      end else begin
         pick = cb;
      end
   end

   assign cram_ra = stall ? pick_ff : ((pick == 6'd0) ? cfg.backdrop : pick);

   tpc_ram #(.WIDTH(16), .DEPTH(tpc_pkg::COLOR_ENTRIES)) u_cram (
      .clock(clock), .wr_en(cwe), .wr_addr(job.addr[tpc_pkg::CRAM_AW-1:0]),
      .wr_data(job.data),
      .rd_addr_0(cram_ra), .rd_addr_1(cram_ra),
      .rd_data_0(cword), .rd_data_1()
   );

   always_comb begin
      v_in = v_ff;
      out_in = out_ff;
      if (rsp_ready) begin
         out_in = 1'b0;
      end
      if (!stall) begin
         v_in[0] = take && job.op == tpc_pkg::OP_RENDER;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         if (v_ff[3]) begin
            out_in = 1'b1;
         end
      end
      v_in[4] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
         out_ff <= out_in;
      end
      ra0_ff <= ra0;
      ra1_ff <= ra1;
      pick_ff <= cram_ra;
      if (!stall) begin
         if (take) begin
            j1_ff <= job;
         end
         hi_a_ff <= rd0;
         hi_b_ff <= rd1;
         j2_ff <= j1_ff;
         if (v_ff[1]) begin
            ent_a_ff <= ea;
            ent_b_ff <= eb;
         end
         j3_ff <= j2_ff;
         high_ff <= hi;
         drawn_ff <= pick != 6'd0;
         if (v_ff[3]) begin
            red_ff <= tpc_pkg::level_scale(cword[3:1]);
            green_ff <= tpc_pkg::level_scale(cword[7:5]);
            blue_ff <= tpc_pkg::level_scale(cword[11:9]);
            high2_ff <= high_ff;
            drawn2_ff <= drawn_ff;
         end
      end
   end

   assign rsp_valid = out_ff;
   assign rsp_red = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue = blue_ff;
   assign rsp_plane_high = high2_ff;
   assign rsp_plane_drawn = drawn2_ff;

endmodule
